/* sv/stt_pkg.sv */
// Shared constants and controller/datapath interface types for the timer table.
`default_nettype none
package stt_pkg;

   localparam int SLOTS = 32;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int TIME_W = 35;
   localparam int MS_TO_US = 1000;

   // Request kinds carried in req_tuser
   localparam logic [1:0] MODE_INS_US = 2'd0;
   localparam logic [1:0] MODE_INS_MS = 2'd1;
   localparam logic [1:0] MODE_TICK   = 2'd2;
   localparam logic [1:0] MODE_NONE   = 2'd3;

   // Result kinds for the output register
   localparam logic [1:0] KIND_OK    = 2'd0;
   localparam logic [1:0] KIND_FULL  = 2'd1;
   localparam logic [1:0] KIND_NONE  = 2'd2;
   localparam logic [1:0] KIND_FIRED = 2'd3;

   typedef struct packed {
      logic       in_latch;
      logic       idx_clear;
      logic       idx_inc;
      logic       ins_write;
      logic       tick_write;
      logic       tick_fire;
      logic       out_load;
      logic [1:0] out_kind;
   } stt_cmd_type;

   typedef struct packed {
      logic active_hit;
      logic fire_hit;
      logic fired_hit;
      logic idx_end;
      logic last_hit;
      logic any_fired;
      logic table_full;
      logic out_free;
   } stt_status_type;

endpackage
`default_nettype wire

/* sv/software_timer_table.sv */
// An insert scans to the lowest free slot and loads its result there; a refused insert or an
// unused mode goes straight to its result load, and a tick without expiry loads after its scan.
// A tick scans every slot, one per cycle, then walks up to the highest fired slot and reports
// each fired slot, waiting on a fired slot while the output register is occupied.
// One request at a time: the next is accepted in the cycle after the last result load; output
// stalls delay result loads. Reset frees all slots, zeroes count, increment 1.
`default_nettype none
module software_timer_table (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_wr_en,
   input  wire  [15:0] csr_wr_data,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // delay_value[23:0], event_tag[31:24]
   input  wire  [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // fired_tag[7:0], fired_slot[12:8], active_timers[18:13]
   output logic [2:0]  rsp_tuser,   // insert_ok[0], table_full[1], fired_valid[2]
   output logic        rsp_tlast    // last_result
);
   import stt_pkg::*;

   stt_cmd_type    cmd;
   stt_status_type status;

   stt_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   stt_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .cmd         (cmd),
      .status      (status)
   );

endmodule
`default_nettype wire

/* sv/stt_controller.sv */
// Sequencer for insert scans, tick scans and fired-timer reporting.
`default_nettype none
module stt_controller (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  wire [1:0]               req_tuser,
   input  stt_pkg::stt_status_type status,
   output stt_pkg::stt_cmd_type    cmd
);
   import stt_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_INSERT = 3'd1;
   localparam logic [2:0] ST_TICK   = 3'd2;
   localparam logic [2:0] ST_EMIT   = 3'd3;
   localparam logic [2:0] ST_RESULT = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [1:0] kind_ff, kind_in;

   assign req_tready = (state_ff == ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.in_latch  = 1'b1;
               cmd.idx_clear = 1'b1;
               unique case (req_tuser) inside
                  MODE_INS_US, MODE_INS_MS: begin
                     if (status.table_full) begin
                        kind_in  = KIND_FULL;
                        state_in = ST_RESULT;
                     end else begin
                        state_in = ST_INSERT;
                     end
                  end
                  MODE_TICK: state_in = ST_TICK;
                  default: begin
                     kind_in  = KIND_NONE;
                     state_in = ST_RESULT;
                  end
               endcase
            end
         end
         ST_INSERT: begin
            if (!status.active_hit) begin
               cmd.ins_write = 1'b1;
               kind_in       = KIND_OK;
               state_in      = ST_RESULT;
            end else if (status.idx_end) begin
               kind_in  = KIND_FULL;
               state_in = ST_RESULT;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_TICK: begin
            if (status.active_hit) begin
               cmd.tick_write = 1'b1;
               cmd.tick_fire  = status.fire_hit;
            end
            if (status.idx_end) begin
               if (status.any_fired || (status.active_hit && status.fire_hit)) begin
                  cmd.idx_clear = 1'b1;
                  state_in      = ST_EMIT;
               end else begin
                  kind_in  = KIND_NONE;
                  state_in = ST_RESULT;
               end
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_EMIT: begin
            if (status.fired_hit) begin
               if (status.out_free) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = KIND_FIRED;
                  if (status.last_hit) begin
                     state_in = ST_IDLE;
                  end else begin
                     cmd.idx_inc = 1'b1;
                  end
               end
            end else if (status.idx_end) begin
               state_in = ST_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_RESULT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = kind_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= KIND_NONE;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("output loaded while occupied");
   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != ST_EMIT))
      else $error("emit entered straight from accept");
   a_emit_fired_only: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && cmd.out_kind == KIND_FIRED) |-> status.fired_hit)
      else $error("fired result without a fired slot");
`endif

endmodule
`default_nettype wire

/* sv/stt_datapath.sv */
// Slot storage, scan index, elapsed-time adder and output register.
`default_nettype none
module stt_datapath (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     csr_wr_en,
   input  wire [15:0]              csr_wr_data,
   input  wire [1:0]               req_tuser,
   input  wire [31:0]              req_tdata,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output logic [23:0]             rsp_tdata,
   output logic [2:0]              rsp_tuser,
   output logic                    rsp_tlast,
   input  stt_pkg::stt_cmd_type    cmd,
   output stt_pkg::stt_status_type status
);
   import stt_pkg::*;

   logic [15:0]       inc_ff;
   logic [TIME_W-1:0] delay_ff;
   logic [7:0]        tag_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  last_ff;
   logic              any_ff;
   logic [SLOTS-1:0]  active_ff;
   logic [SLOTS-1:0]  fired_ff;
   logic [CNT_W-1:0]  count_ff;

   logic [TIME_W-1:0] slot_delay   [SLOTS];
   logic [TIME_W-1:0] slot_elapsed [SLOTS];
   logic [7:0]        slot_tag     [SLOTS];

   logic              out_valid_ff;
   logic [23:0]       out_data_ff;
   logic [2:0]        out_user_ff;
   logic              out_last_ff;

   logic [23:0]       dval;
   logic [33:0]       dval_ms;
   logic [TIME_W-1:0] sum;
   logic [63:0]       idx_wide;
   logic [63:0]       cnt_wide;
   logic              out_free;

   assign dval     = req_tdata[23:0];
   assign dval_ms  = {10'd0, dval} * 34'(MS_TO_US);
   assign sum      = slot_elapsed[idx_ff] + {{(TIME_W - 16){1'b0}}, inc_ff};
   assign idx_wide = {{(64 - IDX_W){1'b0}}, idx_ff};
   assign cnt_wide = {{(64 - CNT_W){1'b0}}, count_ff};
   assign out_free = !out_valid_ff || rsp_tready;

   // Status toward the controller
   always_comb begin
      status.active_hit = active_ff[idx_ff];
      status.fire_hit   = (sum >= slot_delay[idx_ff]);
      status.fired_hit  = fired_ff[idx_ff];
      status.idx_end    = (idx_ff == IDX_W'(SLOTS - 1));
      status.last_hit   = (idx_ff == last_ff);
      status.any_fired  = any_ff;
      status.table_full = (count_ff >= CNT_W'(SLOTS));
      status.out_free   = out_free;
   end

   // Hold tick increment
   always_ff @(posedge clock) begin
      if (reset) begin
         inc_ff <= 16'd1;
      end else if (csr_wr_en) begin
         inc_ff <= csr_wr_data;
      end
   end

   // Capture the request transaction
   always_ff @(posedge clock) begin
      if (cmd.in_latch) begin
         tag_ff <= req_tdata[31:24];
         if (req_tuser == MODE_INS_MS) begin
            delay_ff <= {1'b0, dval_ms};
         end else begin
            delay_ff <= {{(TIME_W - 24){1'b0}}, dval};
         end
      end
   end

   // Advance scan index
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.idx_clear) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // Slot storage writes
   always_ff @(posedge clock) begin
      if (cmd.ins_write) begin
         slot_delay[idx_ff]   <= delay_ff;
         slot_elapsed[idx_ff] <= '0;
         slot_tag[idx_ff]     <= tag_ff;
      end else if (cmd.tick_write) begin
         slot_elapsed[idx_ff] <= sum;
      end
   end

   // Active and fired flags, count, last fired slot
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         fired_ff  <= '0;
         count_ff  <= '0;
         any_ff    <= 1'b0;
         last_ff   <= '0;
      end else begin
         if (cmd.in_latch) begin
            any_ff <= 1'b0;
         end
         if (cmd.ins_write) begin
            active_ff[idx_ff] <= 1'b1;
            count_ff          <= count_ff + 1'b1;
         end else if (cmd.tick_fire) begin
            active_ff[idx_ff] <= 1'b0;
            fired_ff[idx_ff]  <= 1'b1;
            count_ff          <= count_ff - 1'b1;
            any_ff            <= 1'b1;
            last_ff           <= idx_ff;
         end else if (cmd.out_load && cmd.out_kind == KIND_FIRED) begin
            fired_ff[idx_ff] <= 1'b0;
         end
      end
   end

   // Output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_user_ff <= {cmd.out_kind == KIND_FIRED, cmd.out_kind == KIND_FULL,
                         cmd.out_kind == KIND_OK};
         out_last_ff <= (cmd.out_kind != KIND_FIRED) || status.last_hit;
         if (cmd.out_kind == KIND_FIRED) begin
            out_data_ff <= {5'd0, cnt_wide[5:0], idx_wide[4:0], slot_tag[idx_ff]};
         end else begin
            out_data_ff <= {5'd0, cnt_wide[5:0], 13'd0};
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef NO_ASSERTIONS
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(active_ff)))
      else $error("active count disagrees with active flags");
   a_fired_inactive: assert property (@(posedge clock) disable iff (reset)
      (fired_ff & active_ff) == '0)
      else $error("pending fired slot is active");
   a_insert_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_write |-> !active_ff[idx_ff])
      else $error("insert overwrote an active slot");
`endif

endmodule
`default_nettype wire

/* test/tb_software_timer_table.sv */
// Self-checking testbench for the one-shot timer table: directed cases, zero increment, full table, random phases.
module tb_software_timer_table;
   timeunit 1ns;
   timeprecision 1ps;
   import stt_pkg::*;

   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_TICKS = 8;
   localparam int SETTLE_CYCLES = 2 * SLOTS + 8;
   localparam int PHASE_ITEMS = 20;
   localparam int MAX_PRINTS = 20;
   localparam logic [15:0] STEP_MAX = 16'hFFFF;

   typedef struct packed {
      logic       ins_ok;
      logic       full;
      logic       fired;
      logic [7:0] tag;
      logic [4:0] slot;
      logic       is_last;
      logic [5:0] count;
   } timer_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // delay_value[23:0], event_tag[31:24]
   logic [1:0]  req_tuser = MODE_NONE;   // mode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;   // fired_tag[7:0], fired_slot[12:8], active_timers[18:13]
   logic [2:0]  rsp_tuser;   // insert_ok[0], table_full[1], fired_valid[2]
   logic        rsp_tlast;

   // Timer table predictor state
   logic              slot_busy [SLOTS] = '{default: 1'b0};
   logic [TIME_W-1:0] slot_limit [SLOTS];
   logic [TIME_W-1:0] slot_time [SLOTS];
   logic [7:0]        slot_label [SLOTS];
   int                busy_count = 0;
   logic [15:0]       tick_step = 16'd1;
   timer_result_type  pending_results [$];

   bit steady = 1'b0;
   int stall_left = 0;
   int idle_cycles = 0;
   int n_inserts = 0;
   int n_refused = 0;
   int n_ticks = 0;
   int n_fired = 0;
   int n_checked = 0;
   int n_mismatch = 0;

   software_timer_table u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mostly short gaps, a few long ones; none while in steady mode
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      else if (r < 88) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      n_mismatch++;
      if (n_mismatch <= MAX_PRINTS)
         $display("%0t: %s got 0x%0h, want 0x%0h", $realtime, what, got, want);
   endtask

   task automatic compare_field(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   // Apply one accepted transaction to the timer table and queue its results
   task automatic advance_timer_model(input logic [1:0] mode, input logic [23:0] dly,
                                      input logic [7:0] tag);
      timer_result_type r;
      int fired_q [$];
      int free_idx;
      r = '0;
      r.is_last = 1'b1;
      case (mode) inside
         MODE_INS_US, MODE_INS_MS: begin
            free_idx = -1;
            for (int i = SLOTS - 1; i >= 0; i--)
               if (!slot_busy[i]) free_idx = i;
            if (busy_count >= SLOTS || free_idx < 0) begin
               r.full = 1'b1;
               n_refused++;
            end else begin
               slot_busy[free_idx] = 1'b1;
               slot_limit[free_idx] = (mode == MODE_INS_MS) ?
                  TIME_W'(dly) * TIME_W'(MS_TO_US) : TIME_W'(dly);
               slot_time[free_idx] = '0;
               slot_label[free_idx] = tag;
               busy_count++;
               r.ins_ok = 1'b1;
               n_inserts++;
            end
            r.count = 6'(busy_count);
            pending_results.push_back(r);
         end
         MODE_TICK: begin
            n_ticks++;
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_busy[i]) begin
                  slot_time[i] = slot_time[i] + TIME_W'(tick_step);
                  if (slot_time[i] >= slot_limit[i]) begin
                     slot_busy[i] = 1'b0;
                     busy_count--;
                     fired_q.push_back(i);
                  end
               end
            end
            // every result carries the count after the whole tick
            r.count = 6'(busy_count);
            if (fired_q.size() == 0) pending_results.push_back(r);
            foreach (fired_q[k]) begin
               r.fired = 1'b1;
               r.tag = slot_label[fired_q[k]];
               r.slot = 5'(fired_q[k]);
               r.is_last = (k == fired_q.size() - 1);
               pending_results.push_back(r);
               n_fired++;
            end
         end
         default: begin
            r.count = 6'(busy_count);
            pending_results.push_back(r);
         end
      endcase
   endtask

   // Present one transaction after a random gap and hold it until accepted
   task automatic send_request(input logic [1:0] mode, input logic [23:0] dly,
                               input logic [7:0] tag);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {tag, dly};
      do @(posedge clock); while (req_tready !== 1'b1);
      advance_timer_model(mode, dly, tag);
   endtask

   task automatic wait_idle();
      if (req_tvalid) req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_tick_step(input logic [15:0] value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tick_step = value;
   endtask

   // Tick at the largest increment for a few ticks or until every timer has fired
   task automatic drain_timers();
      int n = 0;
      if (tick_step != STEP_MAX) write_tick_step(STEP_MAX);
      while (busy_count > 0 && n < DRAIN_TICKS) begin
         send_request(MODE_TICK, 24'($urandom), 8'($urandom));
         n++;
      end
   endtask

   task automatic send_random_item();
      int r;
      int span;
      logic [23:0] dly;
      r = $urandom_range(0, 99);
      span = 4 * int'(tick_step) + 2;
      if (r < 45) begin
         // keep most delays within a few ticks, now and then a far one
         dly = ($urandom_range(0, 19) == 0) ? 24'($urandom) : 24'($urandom_range(0, span));
         send_request(MODE_INS_US, dly, 8'($urandom));
      end else if (r < 60)
         send_request(MODE_INS_MS, 24'($urandom_range(0, span / 1000 + 1)), 8'($urandom));
      else if (r < 95)
         send_request(MODE_TICK, 24'($urandom), 8'($urandom));
      else
         send_request(MODE_NONE, 24'($urandom), 8'($urandom));
   endtask

   // Field extremes, both insert units, ticks with and without expiries, unused mode
   task automatic test_directed_ops();
      send_request(MODE_NONE, 24'h000000, 8'h00);
      send_request(MODE_INS_US, 24'h000000, 8'h00);
      send_request(MODE_INS_US, 24'hFFFFFF, 8'hFF);
      send_request(MODE_INS_MS, 24'h000001, 8'hA5);
      send_request(MODE_INS_MS, 24'h000000, 8'h5A);
      send_request(MODE_INS_US, 24'h000002, 8'h3C);
      // both zero-delay timers fire on the first tick
      send_request(MODE_TICK, 24'h000000, 8'h00);
      send_request(MODE_TICK, 24'h000000, 8'h00);
      send_request(MODE_TICK, 24'hFFFFFF, 8'hFF);
      send_request(MODE_NONE, 24'hAAAAAA, 8'h55);
      send_request(MODE_INS_US, 24'h555555, 8'h0F);
   endtask

   // With a zero increment only zero-delay timers fire
   task automatic test_zero_increment();
      write_tick_step(16'd0);
      send_request(MODE_INS_US, 24'h000000, 8'h11);
      send_request(MODE_INS_US, 24'h000001, 8'h22);
      send_request(MODE_TICK, 24'h123456, 8'h78);
      send_request(MODE_TICK, 24'h000000, 8'h00);
      write_tick_step(STEP_MAX);
      send_request(MODE_TICK, 24'h000000, 8'h00);
   endtask

   // Fill the free slots, get refused twice, then fire every short timer in one tick
   task automatic test_table_full();
      int n_fill;
      if (tick_step != STEP_MAX) write_tick_step(STEP_MAX);
      n_fill = SLOTS - busy_count + 2;
      steady = 1'b1;
      for (int i = 0; i < n_fill; i++) begin
         if (i % 3 == 2)
            send_request(MODE_INS_MS, 24'($urandom_range(0, 65)), 8'($urandom));
         else
            send_request(MODE_INS_US, 24'($urandom_range(0, 65535)), 8'($urandom));
      end
      send_request(MODE_TICK, 24'($urandom), 8'($urandom));
      steady = 1'b0;
   endtask

   task automatic test_random_phases();
      logic [15:0] steps [5];
      steps = '{16'd1, 16'd3, 16'd1000, STEP_MAX, 16'($urandom_range(1, 65535))};
      foreach (steps[p]) begin
         write_tick_step(steps[p]);
         steady = (p == 1);
         repeat (PHASE_ITEMS) send_random_item();
      end
      steady = 1'b0;
   endtask

   // Result side: random stalls except in steady mode
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!steady && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
   end

   // Compare each result transaction with the oldest expectation
   always @(posedge clock) begin : check_rsp
      timer_result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pending_results.size() == 0)
            report_mismatch("result with nothing pending", rsp_tdata, 0);
         else begin
            want = pending_results.pop_front();
            n_checked++;
            compare_field("insert_ok", rsp_tuser[0], want.ins_ok);
            compare_field("table_full", rsp_tuser[1], want.full);
            compare_field("fired_valid", rsp_tuser[2], want.fired);
            compare_field("fired_tag", rsp_tdata[7:0], want.tag);
            compare_field("fired_slot", rsp_tdata[12:8], want.slot);
            compare_field("active_timers", rsp_tdata[18:13], want.count);
            compare_field("tdata padding", rsp_tdata[23:19], 0);
            compare_field("last_result", rsp_tlast, want.is_last);
         end
      end
   end

   // Stop the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d results pending",
                  IDLE_LIMIT, pending_results.size());
         $display("software_timer_table: mismatch");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_ops();
      test_zero_increment();
      test_table_full();
      test_random_phases();
      drain_timers();
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d inserts, %0d refused on a full table, %0d ticks, %0d expiries",
               n_inserts, n_refused, n_ticks, n_fired);
      $display("checked %0d results over increments 0 to 65535, %0d mismatches",
               n_checked, n_mismatch);
      if (n_mismatch == 0)
         $display("software_timer_table: match");
      else
         $display("software_timer_table: mismatch");
      $finish;
   end

endmodule
